### hw/rtl/mlfd_pkg.sv
package mlfd_pkg;

	// header layout: magic(4) type(2) flags(2) length(4), big-endian
	localparam int unsigned HDR_LEN    = 12;
	localparam int unsigned HDR_CNT_W  = 4;
	localparam int unsigned HDR_BITS   = HDR_LEN * 8;
	localparam logic [31:0] FRAME_MAGIC = 32'h5447_5231;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W  = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LOWEST   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_HIGHEST  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 8'd2;

	localparam logic [15:0] TYPE_LOWEST_RST   = 16'd1;
	localparam logic [15:0] TYPE_HIGHEST_RST  = 16'hFFFF;
	localparam logic [31:0] PAYLOAD_LIMIT_RST = 32'h0010_0000;

	// result status codes
	localparam logic [2:0] ST_PAYLOAD   = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
	localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
	localparam logic [2:0] ST_BAD_FLAGS = 3'd4;
	localparam logic [2:0] ST_TOO_LARGE = 3'd5;

	typedef struct packed {
		logic        fail;
		logic [2:0]  status;
		logic [15:0] frame_type;
		logic [31:0] length;
	} hdr_chk_t;

endpackage

### hw/rtl/mlfd_hdr_check.sv
module mlfd_hdr_check import mlfd_pkg::*; (
	input  logic [HDR_BITS-1:0] hdr_word,
	input  logic [15:0]         type_lowest,
	input  logic [15:0]         type_highest,
	input  logic [31:0]         payload_limit,
	output hdr_chk_t            chk
);

	logic [31:0] magic;
	logic [15:0] ftype;
	logic [15:0] flags;
	logic [31:0] length;

	assign magic  = hdr_word[HDR_BITS-1 -: 32];
	assign ftype  = hdr_word[HDR_BITS-33 -: 16];
	assign flags  = hdr_word[HDR_BITS-49 -: 16];
	assign length = hdr_word[31:0];

	// first failing check wins
	always_comb begin
		chk.frame_type = ftype;
		chk.length     = length;
		chk.fail       = 1'b1;
		if (magic != FRAME_MAGIC) begin
			chk.status = ST_BAD_MAGIC;
		end else if (ftype < type_lowest || ftype > type_highest) begin
			chk.status = ST_BAD_TYPE;
		end else if (flags != 16'd0) begin
			chk.status = ST_BAD_FLAGS;
		end else if (length > payload_limit) begin
			chk.status = ST_TOO_LARGE;
		end else begin
			chk.fail   = 1'b0;
			chk.status = ST_EMPTY;
		end
	end

endmodule

### hw/rtl/magic_length_frame_deframer_unit.sv
// byte-wide deframer for magic/length framed streams. one stream byte is
// taken per clock with no bubbles while the output is not stalled; a taken
// item lands in an input register and its result, if any, is loaded into the
// output register once that register is free or draining, and stays there
// until taken. the header check (magic, type range, flags, length limit) is
// combinational and runs on the twelfth header byte. header bytes give no
// result except when the header is rejected (one error item) or declares
// zero length (one empty frame item). payload bytes come out one per item
// with the frame type and a last mark. after any header error the block
// drops every byte until arst_n. configuration registers are written through
// cfg_* (always ready) and must only be changed while the block is idle.
module magic_length_frame_deframer_unit import mlfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input byte channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           stream_byte,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           status,
	output logic [15:0]          frame_type,
	output logic [7:0]           payload_byte,
	output logic                 last_byte,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	// configuration registers
	logic [15:0] type_lowest_q;
	logic [15:0] type_highest_q;
	logic [31:0] payload_limit_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// deframer state
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [7:0]           hdr_q [HDR_LEN-1];
	logic [31:0]          bytes_left_q;
	logic [15:0]          cur_type_q;
	logic                 failed_q;

	// output register
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] frame_type_q;
	logic [7:0]  payload_byte_q;
	logic        last_byte_q;

	logic          advance;
	logic          in_take;
	logic          hdr_done;
	logic          in_payload;
	logic [HDR_BITS-1:0] hdr_word;
	hdr_chk_t      chk;

	// result produced by the item in the input stage
	logic        res_valid;
	logic [2:0]  res_status;
	logic [15:0] res_type;
	logic [7:0]  res_byte;
	logic        res_last;

	// input stage moves on whenever the output register is free or draining
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign in_payload = (bytes_left_q != 32'd0);
	assign hdr_done   = (hdr_cnt_q == HDR_CNT_W'(HDR_LEN - 1));

	// stored header bytes plus the byte now completing it, first byte on top
	always_comb begin
		hdr_word = '0;
		for (int i = 0; i < HDR_LEN - 1; i++) begin
			hdr_word[(HDR_LEN-1-i)*8 +: 8] = hdr_q[i];
		end
		hdr_word[7:0] = byte_s1;
	end

	mlfd_hdr_check u_hdr_check (
		.hdr_word      (hdr_word),
		.type_lowest   (type_lowest_q),
		.type_highest  (type_highest_q),
		.payload_limit (payload_limit_q),
		.chk           (chk)
	);

	// result of the current item
	always_comb begin
		res_valid  = 1'b0;
		res_status = ST_PAYLOAD;
		res_type   = cur_type_q;
		res_byte   = 8'd0;
		res_last   = 1'b0;
		if (!failed_q) begin
			if (in_payload) begin
				res_valid = 1'b1;
				res_byte  = byte_s1;
				res_last  = (bytes_left_q == 32'd1);
			end else if (hdr_done) begin
				res_type   = chk.frame_type;
				res_status = chk.status;
				if (chk.fail) begin
					res_valid = 1'b1;
				end else if (chk.length == 32'd0) begin
					res_valid = 1'b1;
					res_last  = 1'b1;
				end
			end
		end
	end

	// configuration writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_lowest_q   <= TYPE_LOWEST_RST;
			type_highest_q  <= TYPE_HIGHEST_RST;
			payload_limit_q <= PAYLOAD_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TYPE_LOWEST:   type_lowest_q   <= cfg_data[15:0];
				CFG_TYPE_HIGHEST:  type_highest_q  <= cfg_data[15:0];
				CFG_PAYLOAD_LIMIT: payload_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= stream_byte;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q    <= '0;
			bytes_left_q <= '0;
			cur_type_q   <= '0;
			failed_q     <= 1'b0;
		end else if (advance && !failed_q) begin
			if (in_payload) begin
				bytes_left_q <= bytes_left_q - 32'd1;
			end else if (!hdr_done) begin
				hdr_cnt_q <= hdr_cnt_q + HDR_CNT_W'(1);
			end else begin
				hdr_cnt_q <= '0;
				if (chk.fail) begin
					failed_q <= 1'b1;
				end else begin
					cur_type_q   <= chk.frame_type;
					bytes_left_q <= chk.length;
				end
			end
		end
	end

	// header byte store, undefined until written
	always_ff @(posedge clk) begin
		if (advance && !failed_q && !in_payload) begin
			for (int i = 0; i < HDR_LEN - 1; i++) begin
				if (hdr_cnt_q == HDR_CNT_W'(i)) begin
					hdr_q[i] <= byte_s1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			status_q       <= res_status;
			frame_type_q   <= res_type;
			payload_byte_q <= res_byte;
			last_byte_q    <= res_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign frame_type   = frame_type_q;
	assign payload_byte = payload_byte_q;
	assign last_byte    = last_byte_q;

	// input only backs up behind a full, stalled output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled while output register free");

	// a header error is sticky until reset
	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q)
		else $error("failed flag cleared without reset");

	// payload is never counted down in the middle of a header
	a_payload_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(bytes_left_q != 32'd0) |-> (hdr_cnt_q == '0))
		else $error("payload pending with partial header");

	// header counter stays within the header
	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= HDR_CNT_W'(HDR_LEN - 1))
		else $error("header counter out of range");

endmodule

### test/tb_magic_length_frame_deframer_unit.sv
`timescale 1ns / 100ps

module tb_magic_length_frame_deframer_unit;
	import mlfd_pkg::*;

	// idle time after a drain before a register write
	localparam int SETTLE_CYCLES = 6;
	// byte count at which the random part stops starting new settings
	localparam int RANDOM_ITEMS = 800;
	// register indexes outside the list, writes to them must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP    = 8'hFF;

	// header faults, only one can be reached per run since a fault sticks until reset
	typedef enum int {
		FAULT_MAGIC,
		FAULT_TYPE,
		FAULT_FLAGS,
		FAULT_LENGTH,
		FAULT_EMPTY_RANGE,
		FAULT_SEVERAL
	} fault_kind_e;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] ftype;
		logic [7:0]  data;
		logic        last;
	} frame_out_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           stream_byte = 8'h00;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [2:0]           status;
	logic [15:0]          frame_type;
	logic [7:0]           payload_byte;
	logic                 last_byte;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	// predicted deframer state and register copies
	logic [15:0] type_lo;
	logic [15:0] type_hi;
	logic [31:0] len_limit;
	logic [95:0] hdr_shift;
	logic [3:0]  hdr_count;
	logic [31:0] bytes_due;
	logic [15:0] run_type;
	logic        locked_out;

	frame_out_t  expected_q[$];
	int          mismatches = 0;
	int          items_sent = 0;
	bit          idle_on = 1'b0;
	int          stall_left = 0;

	magic_length_frame_deframer_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.stream_byte  (stream_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.frame_type   (frame_type),
		.payload_byte (payload_byte),
		.last_byte    (last_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// append one predicted item at the tail of the queue
	function automatic void queue_result(input logic [2:0] st, input logic [15:0] ty,
		input logic [7:0] d, input logic l);
		frame_out_t r;
		r = '{st, ty, d, l};
		expected_q.insert(expected_q.size(), r);
	endfunction

	// predict what one accepted stream byte produces
	function automatic void deframe_byte(input logic [7:0] b);
		logic [15:0] ty;
		logic [15:0] fl;
		logic [31:0] len;
		if (locked_out) begin
			// after a header fault every byte is dropped
		end else if (bytes_due != 0) begin
			queue_result(ST_PAYLOAD, run_type, b, bytes_due == 32'd1);
			bytes_due--;
		end else begin
			hdr_shift = {hdr_shift[87:0], b};
			hdr_count++;
			if (hdr_count == HDR_LEN) begin
				hdr_count = '0;
				ty  = hdr_shift[63:48];
				fl  = hdr_shift[47:32];
				len = hdr_shift[31:0];
				// checks in priority order, first failure wins
				if (hdr_shift[95:64] != FRAME_MAGIC) begin
					locked_out = 1'b1;
					queue_result(ST_BAD_MAGIC, ty, 8'h00, 1'b0);
				end else if (ty < type_lo || ty > type_hi) begin
					locked_out = 1'b1;
					queue_result(ST_BAD_TYPE, ty, 8'h00, 1'b0);
				end else if (fl != 16'h0000) begin
					locked_out = 1'b1;
					queue_result(ST_BAD_FLAGS, ty, 8'h00, 1'b0);
				end else if (len > len_limit) begin
					locked_out = 1'b1;
					queue_result(ST_TOO_LARGE, ty, 8'h00, 1'b0);
				end else begin
					run_type = ty;
					if (len == 32'd0)
						queue_result(ST_EMPTY, ty, 8'h00, 1'b1);
					else
						bytes_due = len;
				end
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// result checker, compares each accepted item against the oldest prediction
	always @(posedge clk) begin : check_results
		frame_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected item status", 32'(status), 32'h0);
			end else begin
				want = expected_q.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (frame_type !== want.ftype)
					report_mismatch("frame_type", 32'(frame_type), 32'(want.ftype));
				if (payload_byte !== want.data)
					report_mismatch("payload_byte", 32'(payload_byte), 32'(want.data));
				if (last_byte !== want.last)
					report_mismatch("last_byte", 32'(last_byte), 32'(want.last));
			end
		end
	end

	// receiver back-pressure: random stall bursts, started only while idling is on
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 6);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// send one stream byte, maybe after a random gap, and predict its effect
	task automatic push_byte(input logic [7:0] b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (in_stall);
		deframe_byte(b);
		items_sent++;
	endtask

	task automatic send_header(input logic [31:0] magic, input logic [15:0] ty,
		input logic [15:0] fl, input logic [31:0] len);
		logic [95:0] hdr;
		hdr = {magic, ty, fl, len};
		for (int i = 0; i < HDR_LEN; i++)
			push_byte(hdr[95 - 8 * i -: 8]);
	endtask

	task automatic send_frame(input logic [15:0] ty, input logic [31:0] len);
		send_header(FRAME_MAGIC, ty, 16'h0000, len);
		for (int i = 0; i < len; i++)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	// write one register, only called while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TYPE_LOWEST:   type_lo = val[15:0];
			CFG_TYPE_HIGHEST:  type_hi = val[15:0];
			CFG_PAYLOAD_LIMIT: len_limit = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// write all three registers, junk in the unused upper bits of the type bounds
	task automatic load_config(input logic [15:0] lo, input logic [15:0] hi,
		input logic [31:0] limit);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(CFG_TYPE_LOWEST, {junk[31:16], lo});
		write_reg(CFG_TYPE_HIGHEST, {junk[15:0], hi});
		write_reg(CFG_PAYLOAD_LIMIT, limit);
	endtask

	// stop sending and wait for every predicted item to come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// drain, then let the pipeline empty before any register write
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// reset values: lowest and highest type, empty frame, extreme payload bytes
	task automatic test_default_config();
		send_frame(TYPE_LOWEST_RST, 0);
		send_header(FRAME_MAGIC, TYPE_HIGHEST_RST, 16'h0000, 32'd4);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h55);
		push_byte(8'hAA);
		send_frame(16'h8000, 1);
		settle();
	endtask

	// type window at both extremes and a narrow window hit on its edges
	task automatic test_type_range();
		load_config(16'h0000, 16'h0000, PAYLOAD_LIMIT_RST);
		send_frame(16'h0000, 2);
		settle();
		load_config(16'hFFFF, 16'hFFFF, PAYLOAD_LIMIT_RST);
		send_frame(16'hFFFF, 0);
		settle();
		load_config(16'h1234, 16'h1240, PAYLOAD_LIMIT_RST);
		send_frame(16'h1234, 1);
		send_frame(16'h1240, 3);
		settle();
		// writes past the register list are dropped, window must stay as it was
		write_reg(CFG_IDX_UNUSED, $urandom);
		write_reg(CFG_IDX_TOP, $urandom);
		send_frame(16'h1237, 0);
		settle();
	endtask

	// payload limit at zero, at a length boundary, and at all ones
	task automatic test_payload_limit();
		write_reg(CFG_PAYLOAD_LIMIT, 32'd0);
		send_frame(16'h1238, 0);
		settle();
		write_reg(CFG_PAYLOAD_LIMIT, 32'd5);
		send_frame(16'h1235, 5);
		send_frame(16'h1239, 4);
		settle();
		write_reg(CFG_PAYLOAD_LIMIT, 32'hFFFF_FFFF);
		send_frame(16'h123A, 6);
		settle();
	endtask

	// well-formed frames with random content under random register settings
	task automatic test_random_frames();
		logic [15:0] lo;
		logic [15:0] hi;
		logic [31:0] limit;
		logic [31:0] len;
		int          cap;
		int          frames;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				lo = 16'h0000;
				hi = 16'hFFFF;
			end else begin
				lo = 16'($urandom_range(0, 65535));
				hi = 16'($urandom_range(lo, 65535));
			end
			case ($urandom_range(0, 4))
				0:       limit = 32'hFFFF_FFFF;
				1:       limit = $urandom_range(0, 3);
				2:       limit = $urandom;
				default: limit = $urandom_range(8, 80);
			endcase
			cap = (limit > 40) ? 40 : int'(limit);
			load_config(lo, hi, limit);
			idle_on = ($urandom_range(0, 3) != 0);
			frames  = $urandom_range(3, 10);
			for (int f = 0; f < frames; f++) begin
				// mostly short payloads, now and then up to the cap which may be the limit
				if ($urandom_range(0, 3) == 0)
					len = $urandom_range(0, cap);
				else
					len = $urandom_range(0, (cap < 8) ? cap : 8);
				send_frame(16'($urandom_range(lo, hi)), len);
				// hold the sender once per setting until every result is out
				if (f == 0)
					drain();
			end
			settle();
		end
	endtask

	// one header fault, then noise that must be dropped
	task automatic test_header_fault();
		fault_kind_e kind;
		logic [31:0] magic;
		logic [15:0] ty;
		logic [15:0] fl;
		logic [31:0] len;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [31:0] limit;
		idle_on = 1'b0;
		kind  = fault_kind_e'($urandom_range(0, FAULT_SEVERAL));
		magic = FRAME_MAGIC;
		fl    = 16'h0000;
		len   = $urandom;
		limit = 32'hFFFF_FFFF;
		lo    = 16'($urandom_range(0, 65535));
		hi    = 16'($urandom_range(lo, 65535));
		ty    = 16'($urandom_range(lo, hi));
		case (kind)
			FAULT_MAGIC: magic = magic ^ (32'h1 << $urandom_range(0, 31));
			FAULT_TYPE: begin
				// just outside the window on one side
				lo = 16'($urandom_range(1, 65534));
				hi = 16'($urandom_range(lo, 65534));
				ty = $urandom_range(0, 1) ? lo - 16'd1 : hi + 16'd1;
			end
			FAULT_FLAGS: fl = 16'($urandom_range(1, 65535));
			FAULT_LENGTH: begin
				limit = $urandom_range(0, 32'hFFFF_FFFE);
				len   = $urandom_range(0, 1) ? limit + 32'd1
					: $urandom_range(limit + 32'd1, 32'hFFFF_FFFF);
			end
			FAULT_EMPTY_RANGE: begin
				// lower bound above upper bound, nothing can pass
				hi = 16'($urandom_range(0, 65534));
				lo = 16'($urandom_range(hi + 1, 65535));
				ty = 16'($urandom_range(0, 65535));
			end
			default: begin
				// flags and length both bad, magic sometimes too: only the first counts
				if ($urandom_range(0, 1) == 0)
					magic = magic ^ (32'h1 << $urandom_range(0, 31));
				fl    = 16'($urandom_range(1, 65535));
				limit = 32'd0;
				len   = $urandom_range(1, 32'hFFFF_FFFF);
			end
		endcase
		load_config(lo, hi, limit);
		send_header(magic, ty, fl, len);
		// locked out now, a clean empty frame and random bytes must give nothing
		send_header(FRAME_MAGIC, lo, 16'h0000, 32'd0);
		repeat (40) push_byte(8'($urandom_range(0, 255)));
		settle();
	endtask

	initial begin
		type_lo    = TYPE_LOWEST_RST;
		type_hi    = TYPE_HIGHEST_RST;
		len_limit  = PAYLOAD_LIMIT_RST;
		hdr_shift  = '0;
		hdr_count  = '0;
		bytes_due  = '0;
		run_type   = '0;
		locked_out = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_config();
		test_type_range();
		test_payload_limit();
		test_random_frames();
		test_header_fault();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog, far beyond the slowest passing run
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
